// ----- src/sfct_pkg.sv -----
// ----------------------------------------------------------------------------
// sfct_pkg - shared types and constants of the sorted fault code table
// Sizes, operation and outcome codes, status bit positions and the records
// passed between the sequencer, the compare unit and the top level.
// ----------------------------------------------------------------------------
package sfct_pkg;

  localparam int CAPACITY    = 32;
  localparam int MAX_RESULTS = 32;

  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int MCNT_W = $clog2(MAX_RESULTS + 1);

  localparam int OP_W    = 3;
  localparam int CODE_W  = 24;
  localparam int STAT_W  = 8;
  localparam int POS_W   = 5;
  localparam int OUTC_W  = 3;
  localparam int SCNT_W  = 6;
  localparam int ENTRY_W = CODE_W + STAT_W;
  localparam int CMP_W   = (POS_W > CNT_W) ? POS_W : CNT_W;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_USED_W = OUTC_W + CODE_W + STAT_W + SCNT_W;

  // operation codes
  localparam logic [OP_W-1:0] OP_ADD       = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE    = 3'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP    = 3'd2;
  localparam logic [OP_W-1:0] OP_READ      = 3'd3;
  localparam logic [OP_W-1:0] OP_LIST_CONF = 3'd4;
  localparam logic [OP_W-1:0] OP_LIST_PEND = 3'd5;

  // outcome codes
  localparam logic [OUTC_W-1:0] OUTC_OK        = 3'd0;
  localparam logic [OUTC_W-1:0] OUTC_DUPLICATE = 3'd1;
  localparam logic [OUTC_W-1:0] OUTC_NOT_FOUND = 3'd2;
  localparam logic [OUTC_W-1:0] OUTC_FULL      = 3'd3;
  localparam logic [OUTC_W-1:0] OUTC_POS_RANGE = 3'd4;

  // status byte bits
  localparam int ST_FAILED_BIT    = 0;
  localparam int ST_PENDING_BIT   = 2;
  localparam int ST_CONFIRMED_BIT = 3;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [CODE_W-1:0] code;
  } entry_t;

  typedef struct packed {
    logic [POS_W-1:0]  position;
    logic [STAT_W-1:0] fault_status;
    logic [CODE_W-1:0] fault_code;
    logic [OP_W-1:0]   opcode;
  } item_t;

  typedef struct packed {
    logic [OUTC_W-1:0] outcome;
    logic              has_entry;
    logic [CODE_W-1:0] entry_code;
    logic [STAT_W-1:0] entry_status;
    logic [SCNT_W-1:0] stored_count;
    logic              last;
  } res_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic eq;
    logic lt;
    logic hit;
  } cmp_t;

endpackage

// ----- src/sfct_ram.sv -----
// ----------------------------------------------------------------------------
// sfct_ram - generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sfct_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/sfct_cmp.sv -----
// ----------------------------------------------------------------------------
// sfct_cmp - shared compare unit
// Compare one stored entry against the search key and test its status byte.
// ----------------------------------------------------------------------------
module sfct_cmp (
  input  sfct_pkg::entry_t                entry,
  input  logic [sfct_pkg::CODE_W-1:0]     key_code,
  input  logic                            sel_pending,
  output sfct_pkg::cmp_t                  result
);

  logic st_failed;
  logic st_pending;
  logic st_confirmed;

  assign st_failed    = entry.status[sfct_pkg::ST_FAILED_BIT];
  assign st_pending   = entry.status[sfct_pkg::ST_PENDING_BIT];
  assign st_confirmed = entry.status[sfct_pkg::ST_CONFIRMED_BIT];

  always_comb begin
    result.eq  = (entry.code == key_code);
    result.lt  = (entry.code < key_code);
    // pending: bit 2 set, bit 3 clear; confirmed: bits 0 and 3 set
    result.hit = sel_pending ? (st_pending & ~st_confirmed)
                             : (st_failed & st_confirmed);
  end

endmodule

// ----- src/sfct_ctrl.sv -----
// ----------------------------------------------------------------------------
// sfct_ctrl - operation sequencer
// Walk the table through the RAM read port, drive the shared compare unit,
// shift entries for insert and delete, and hand results to the output stage.
// ----------------------------------------------------------------------------
module sfct_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  sfct_pkg::item_t              in_item,
  output sfct_pkg::ram_req_t           ram_req,
  input  sfct_pkg::entry_t             rd_data,
  input  logic                         res_ready,
  output logic                         res_push,
  output sfct_pkg::res_t               res
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT,
    S_INSERT,
    S_READ,
    S_READ_WAIT,
    S_LIST,
    S_LIST_END,
    S_EMIT
  } state_t;

  state_t                           state;
  logic [sfct_pkg::OP_W-1:0]        op;
  logic [sfct_pkg::CODE_W-1:0]      key_code;
  logic [sfct_pkg::STAT_W-1:0]      key_status;
  logic [sfct_pkg::POS_W-1:0]       key_pos;
  logic [sfct_pkg::CNT_W-1:0]       occ;
  logic [sfct_pkg::CNT_W-1:0]       nxt;
  logic                             rd_vld;
  logic [sfct_pkg::IDX_W-1:0]       rd_idx;
  logic                             found;
  logic [sfct_pkg::CNT_W-1:0]       ins_idx;
  logic [sfct_pkg::IDX_W-1:0]       src;
  logic [sfct_pkg::CNT_W-1:0]       moves;
  logic                             pend;
  logic [sfct_pkg::IDX_W-1:0]       pend_dst;
  sfct_pkg::entry_t                 entry;
  sfct_pkg::entry_t                 held;
  logic                             held_v;
  logic [sfct_pkg::MCNT_W-1:0]      mcnt;
  logic [sfct_pkg::OUTC_W-1:0]      outc;
  logic                             has;

  sfct_pkg::cmp_t                   cmp;
  logic                             stall;
  logic                             consume;
  logic                             match_in;
  logic [sfct_pkg::MCNT_W-1:0]      mcnt_next;
  logic                             list_issue;
  logic                             is_add;

  sfct_cmp u_cmp (
    .entry       (rd_data),
    .key_code    (key_code),
    .sel_pending (op == sfct_pkg::OP_LIST_PEND),
    .result      (cmp)
  );

  assign in_ready = (state == S_IDLE);
  assign is_add   = (op == sfct_pkg::OP_ADD);

  // list walk: stall on a second match while the output stage is full
  assign match_in   = rd_vld & cmp.hit;
  assign stall      = match_in & held_v & ~res_ready;
  assign consume    = ~stall;
  assign mcnt_next  = mcnt + sfct_pkg::MCNT_W'(match_in);
  assign list_issue = consume && (nxt < occ) &&
                      (mcnt_next != sfct_pkg::MCNT_W'(sfct_pkg::MAX_RESULTS));

  always_comb begin
    ram_req.we    = 1'b0;
    ram_req.waddr = pend_dst;
    ram_req.wdata = rd_data;
    ram_req.raddr = nxt[sfct_pkg::IDX_W-1:0];
    case (state)
      S_SHIFT: begin
        ram_req.raddr = src;
        ram_req.we    = pend;
      end
      S_INSERT: begin
        ram_req.we           = 1'b1;
        ram_req.waddr        = ins_idx[sfct_pkg::IDX_W-1:0];
        ram_req.wdata.code   = key_code;
        ram_req.wdata.status = key_status;
      end
      S_READ: begin
        ram_req.raddr = sfct_pkg::IDX_W'(key_pos);
      end
      S_LIST: begin
        ram_req.raddr = stall ? rd_idx : nxt[sfct_pkg::IDX_W-1:0];
      end
      default: begin
        ram_req.raddr = nxt[sfct_pkg::IDX_W-1:0];
      end
    endcase
  end

  always_comb begin
    res_push           = 1'b0;
    res.outcome        = outc;
    res.has_entry      = has;
    res.entry_code     = has ? entry.code : '0;
    res.entry_status   = has ? entry.status : '0;
    res.stored_count   = sfct_pkg::SCNT_W'(occ);
    res.last           = 1'b1;
    case (state)
      S_EMIT: begin
        res_push = res_ready;
      end
      S_LIST: begin
        // emit the held match once a later one proves it is not the last
        res_push         = consume & match_in & held_v;
        res.outcome      = sfct_pkg::OUTC_OK;
        res.has_entry    = 1'b1;
        res.entry_code   = held.code;
        res.entry_status = held.status;
        res.last         = 1'b0;
      end
      S_LIST_END: begin
        res_push         = res_ready;
        res.outcome      = sfct_pkg::OUTC_OK;
        res.has_entry    = held_v;
        res.entry_code   = held_v ? held.code : '0;
        res.entry_status = held_v ? held.status : '0;
      end
      default: begin
        res_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      occ    <= '0;
      rd_vld <= 1'b0;
      pend   <= 1'b0;
      held_v <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op         <= in_item.opcode;
            key_code   <= in_item.fault_code;
            key_status <= in_item.fault_status;
            key_pos    <= in_item.position;
            nxt        <= '0;
            rd_vld     <= 1'b0;
            pend       <= 1'b0;
            held_v     <= 1'b0;
            mcnt       <= '0;
            case (in_item.opcode)
              sfct_pkg::OP_ADD, sfct_pkg::OP_REMOVE, sfct_pkg::OP_LOOKUP: begin
                if (occ == '0) begin
                  found   <= 1'b0;
                  ins_idx <= '0;
                  state   <= S_DECIDE;
                end else begin
                  state <= S_SCAN;
                end
              end
              sfct_pkg::OP_READ: begin
                state <= S_READ;
              end
              sfct_pkg::OP_LIST_CONF, sfct_pkg::OP_LIST_PEND: begin
                state <= S_LIST;
              end
              default: begin
                outc  <= sfct_pkg::OUTC_OK;
                has   <= 1'b0;
                state <= S_EMIT;
              end
            endcase
          end
        end
        S_SCAN: begin
          // sorted table: stop at the first entry not below the key
          if (rd_vld && !cmp.lt) begin
            found   <= cmp.eq;
            ins_idx <= sfct_pkg::CNT_W'(rd_idx);
            entry   <= rd_data;
            rd_vld  <= 1'b0;
            state   <= S_DECIDE;
          end else if (rd_vld &&
                       (sfct_pkg::CNT_W'(rd_idx) + sfct_pkg::CNT_W'(1) == occ)) begin
            found   <= 1'b0;
            ins_idx <= occ;
            rd_vld  <= 1'b0;
            state   <= S_DECIDE;
          end else if (nxt < occ) begin
            rd_idx <= nxt[sfct_pkg::IDX_W-1:0];
            rd_vld <= 1'b1;
            nxt    <= nxt + sfct_pkg::CNT_W'(1);
          end else begin
            rd_vld <= 1'b0;
          end
        end
        S_DECIDE: begin
          case (op)
            sfct_pkg::OP_ADD: begin
              if (found) begin
                outc  <= sfct_pkg::OUTC_DUPLICATE;
                has   <= 1'b0;
                state <= S_EMIT;
              end else if (occ == sfct_pkg::CNT_W'(sfct_pkg::CAPACITY)) begin
                outc  <= sfct_pkg::OUTC_FULL;
                has   <= 1'b0;
                state <= S_EMIT;
              end else begin
                src   <= sfct_pkg::IDX_W'(occ - sfct_pkg::CNT_W'(1));
                moves <= occ - ins_idx;
                state <= S_SHIFT;
              end
            end
            sfct_pkg::OP_REMOVE: begin
              if (!found) begin
                outc  <= sfct_pkg::OUTC_NOT_FOUND;
                has   <= 1'b0;
                state <= S_EMIT;
              end else begin
                src   <= sfct_pkg::IDX_W'(ins_idx + sfct_pkg::CNT_W'(1));
                moves <= occ - ins_idx - sfct_pkg::CNT_W'(1);
                state <= S_SHIFT;
              end
            end
            default: begin
              outc  <= found ? sfct_pkg::OUTC_OK : sfct_pkg::OUTC_NOT_FOUND;
              has   <= found;
              state <= S_EMIT;
            end
          endcase
        end
        S_SHIFT: begin
          // one move a cycle: read the source now, write it in the next cycle
          if (moves != '0) begin
            pend     <= 1'b1;
            pend_dst <= is_add ? src + sfct_pkg::IDX_W'(1) : src - sfct_pkg::IDX_W'(1);
            src      <= is_add ? src - sfct_pkg::IDX_W'(1) : src + sfct_pkg::IDX_W'(1);
            moves    <= moves - sfct_pkg::CNT_W'(1);
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              if (is_add) begin
                state <= S_INSERT;
              end else begin
                occ   <= occ - sfct_pkg::CNT_W'(1);
                outc  <= sfct_pkg::OUTC_OK;
                has   <= 1'b0;
                state <= S_EMIT;
              end
            end
          end
        end
        S_INSERT: begin
          occ   <= occ + sfct_pkg::CNT_W'(1);
          outc  <= sfct_pkg::OUTC_OK;
          has   <= 1'b0;
          state <= S_EMIT;
        end
        S_READ: begin
          if (sfct_pkg::CMP_W'(key_pos) >= sfct_pkg::CMP_W'(occ)) begin
            outc  <= sfct_pkg::OUTC_POS_RANGE;
            has   <= 1'b0;
            state <= S_EMIT;
          end else begin
            state <= S_READ_WAIT;
          end
        end
        S_READ_WAIT: begin
          entry <= rd_data;
          outc  <= sfct_pkg::OUTC_OK;
          has   <= 1'b1;
          state <= S_EMIT;
        end
        S_LIST: begin
          if (consume) begin
            if (match_in) begin
              held   <= rd_data;
              held_v <= 1'b1;
              mcnt   <= mcnt_next;
            end
            if (list_issue) begin
              rd_idx <= nxt[sfct_pkg::IDX_W-1:0];
              rd_vld <= 1'b1;
              nxt    <= nxt + sfct_pkg::CNT_W'(1);
            end else begin
              rd_vld <= 1'b0;
              state  <= S_LIST_END;
            end
          end
        end
        S_LIST_END: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // occupancy never passes the table size
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= sfct_pkg::CNT_W'(sfct_pkg::CAPACITY))
    else $error("occupancy beyond capacity");

  // the table is written only while shifting or inserting
  a_write_window: assert property (@(posedge clk) disable iff (rst)
    ram_req.we |-> (state == S_SHIFT || state == S_INSERT))
    else $error("table written outside an update");

  // a result is handed over only when the output stage can take it
  a_push_ready: assert property (@(posedge clk) disable iff (rst)
    res_push |-> res_ready)
    else $error("result pushed into a full output stage");

  // an insert grows the table by exactly one entry
  a_insert_grow: assert property (@(posedge clk) disable iff (rst)
    state == S_INSERT |=> occ == $past(occ) + sfct_pkg::CNT_W'(1))
    else $error("insert did not grow occupancy by one");

endmodule

// ----- src/sorted_fault_code_table.sv -----
// ----------------------------------------------------------------------------
// sorted_fault_code_table - sorted table of unique fault codes with status
// Stream-in operation items, stream-out result items over an output register.
// ----------------------------------------------------------------------------
// The block holds up to CAPACITY (32) unique 24-bit fault codes, each with a
// status byte, kept in ascending code order in one RAM. It takes one item at
// a time and deasserts s_tready until every result of that item has been
// handed to the output register. The table is walked through the RAM's single
// registered read port by one shared compare unit, one entry per cycle while a
// list is not stalled by a full output register, so the time per item follows
// the occupancy n: a lookup walks to the slot, an add or remove walks to the
// slot and then shifts the rest of the table by one place, a read fetches its
// position directly, and a list walks all n entries plus any output stalls.
// A list gives one result per matching entry in table
// order, the final one marked by tlast, or a single result without an entry
// if nothing matches; every other operation gives exactly one result with
// tlast set. Table contents need no clearing after reset: only entries below
// the occupancy count are ever read.
// ----------------------------------------------------------------------------
module sorted_fault_code_table (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // opcode[2:0], fault_code[26:3], fault_status[34:27], position[39:35]
  input  logic [sfct_pkg::IN_DATA_W-1:0]       s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // outcome[2:0], entry_code[26:3], entry_status[34:27], stored_count[40:35]
  output logic [sfct_pkg::OUT_DATA_W-1:0]      m_tdata,
  // has_entry[0]
  output logic                                 m_tuser,
  output logic                                 m_tlast
);

  sfct_pkg::item_t    in_item;
  sfct_pkg::ram_req_t ram_req;
  sfct_pkg::entry_t   rd_data;
  sfct_pkg::res_t     res;
  logic               res_ready;
  logic               res_push;

  assign in_item = sfct_pkg::item_t'(s_tdata);

  sfct_ram #(
    .WIDTH (sfct_pkg::ENTRY_W),
    .DEPTH (sfct_pkg::CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (rd_data)
  );

  sfct_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (in_item),
    .ram_req   (ram_req),
    .rd_data   (rd_data),
    .res_ready (res_ready),
    .res_push  (res_push),
    .res       (res)
  );

  // output register: take a new item when empty or being drained this cycle
  assign res_ready = ~m_tvalid | m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // payload: hold while stalled, load on push
  always_ff @(posedge clk) begin
    if (res_push) begin
      m_tdata <= {{(sfct_pkg::OUT_DATA_W - sfct_pkg::OUT_USED_W){1'b0}},
                  res.stored_count, res.entry_status, res.entry_code, res.outcome};
      m_tuser <= res.has_entry;
      m_tlast <= res.last;
    end
  end

  // a held result is never overwritten before it is taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !res_push)
    else $error("output register overwritten while stalled");

  // no new item is taken while a result is being produced
  a_busy_closed: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !s_tready)
    else $error("input open while results pending");

  // every result without an entry, such as the empty-list result, carries tlast
  a_no_entry_last: assert property (@(posedge clk) disable iff (rst)
    (res_push && !res.has_entry) |-> res.last)
    else $error("result without entry lacks last mark");

endmodule

// ----- dv/sfct_result_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfct_result_checker - scoreboard for the sorted fault code table
// Watches both stream channels, keeps its own sorted table of codes and
// status bytes, predicts each result item and compares it field by field.
// ----------------------------------------------------------------------------
module sfct_result_checker
  import sfct_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  m_tuser,
  input  logic                  m_tlast,
  output int                    mismatches,
  output int                    outstanding,
  output int                    results_seen,
  output int                    full_refusals
);

  logic [CODE_W-1:0] table_codes  [CAPACITY];
  logic [STAT_W-1:0] table_status [CAPACITY];
  int                table_fill;
  res_t              expected_results [$];

  // index of a code, or the fill level when it is absent
  function automatic int find_slot(input logic [CODE_W-1:0] code);
    int i;
    for (i = 0; i < table_fill; i++)
      if (table_codes[i] == code) return i;
    return table_fill;
  endfunction

  function automatic logic status_match(input logic [OP_W-1:0] op,
                                        input logic [STAT_W-1:0] st);
    if (op == OP_LIST_CONF)
      return st[ST_FAILED_BIT] && st[ST_CONFIRMED_BIT];
    return st[ST_PENDING_BIT] && !st[ST_CONFIRMED_BIT];
  endfunction

  task automatic queue_result(input logic [OUTC_W-1:0] outc, input logic has,
                              input logic [CODE_W-1:0] code,
                              input logic [STAT_W-1:0] st, input logic fin);
    res_t r;
    r.outcome      = outc;
    r.has_entry    = has;
    r.entry_code   = has ? code : '0;
    r.entry_status = has ? st : '0;
    r.stored_count = SCNT_W'(table_fill);
    r.last         = fin;
    expected_results.insert(expected_results.size(), r);
  endtask

  task automatic apply_table_op(input item_t it);
    int slot;
    int i;
    int matched;
    int emitted;
    slot = find_slot(it.fault_code);
    case (it.opcode)
      OP_ADD: begin
        if (slot < table_fill) begin
          queue_result(OUTC_DUPLICATE, 1'b0, '0, '0, 1'b1);
        end else if (table_fill >= CAPACITY) begin
          full_refusals++;
          queue_result(OUTC_FULL, 1'b0, '0, '0, 1'b1);
        end else begin
          // find the insertion point, then open a gap for the new entry
          slot = 0;
          while (slot < table_fill && table_codes[slot] < it.fault_code) slot++;
          for (i = table_fill; i > slot; i--) begin
            table_codes[i]  = table_codes[i-1];
            table_status[i] = table_status[i-1];
          end
          table_codes[slot]  = it.fault_code;
          table_status[slot] = it.fault_status;
          table_fill++;
          queue_result(OUTC_OK, 1'b0, '0, '0, 1'b1);
        end
      end
      OP_REMOVE: begin
        if (slot >= table_fill) begin
          queue_result(OUTC_NOT_FOUND, 1'b0, '0, '0, 1'b1);
        end else begin
          for (i = slot; i + 1 < table_fill; i++) begin
            table_codes[i]  = table_codes[i+1];
            table_status[i] = table_status[i+1];
          end
          table_fill--;
          queue_result(OUTC_OK, 1'b0, '0, '0, 1'b1);
        end
      end
      OP_LOOKUP: begin
        if (slot >= table_fill)
          queue_result(OUTC_NOT_FOUND, 1'b0, '0, '0, 1'b1);
        else
          queue_result(OUTC_OK, 1'b1, table_codes[slot], table_status[slot], 1'b1);
      end
      OP_READ: begin
        if (int'(it.position) >= table_fill)
          queue_result(OUTC_POS_RANGE, 1'b0, '0, '0, 1'b1);
        else
          queue_result(OUTC_OK, 1'b1, table_codes[it.position],
                       table_status[it.position], 1'b1);
      end
      OP_LIST_CONF, OP_LIST_PEND: begin
        // count first so the final emitted entry can carry the last mark
        matched = 0;
        for (i = 0; i < table_fill; i++)
          if (status_match(it.opcode, table_status[i])) matched++;
        if (matched > MAX_RESULTS) matched = MAX_RESULTS;
        emitted = 0;
        for (i = 0; i < table_fill && emitted < matched; i++) begin
          if (status_match(it.opcode, table_status[i])) begin
            emitted++;
            queue_result(OUTC_OK, 1'b1, table_codes[i], table_status[i],
                         emitted == matched);
          end
        end
        if (matched == 0) queue_result(OUTC_OK, 1'b0, '0, '0, 1'b1);
      end
      default: queue_result(OUTC_OK, 1'b0, '0, '0, 1'b1);
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result();
    res_t want;
    results_seen++;
    if (expected_results.size() == 0) begin
      $error("result item with no prediction pending: tdata 0x%0h", m_tdata);
      mismatches++;
    end else begin
      want = expected_results.pop_front();
      check_field("outcome", 32'(want.outcome), 32'(m_tdata[OUTC_W-1:0]));
      check_field("has_entry", 32'(want.has_entry), 32'(m_tuser));
      check_field("entry_code", 32'(want.entry_code),
                  32'(m_tdata[OUTC_W +: CODE_W]));
      check_field("entry_status", 32'(want.entry_status),
                  32'(m_tdata[OUTC_W+CODE_W +: STAT_W]));
      check_field("stored_count", 32'(want.stored_count),
                  32'(m_tdata[OUTC_W+CODE_W+STAT_W +: SCNT_W]));
      check_field("last", 32'(want.last), 32'(m_tlast));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      table_fill = 0;
      expected_results.delete();
    end else begin
      // predict before checking so a result can never overtake its item
      if (s_tvalid && s_tready) apply_table_op(item_t'(s_tdata));
      if (m_tvalid && m_tready) check_result();
    end
    outstanding = expected_results.size();
  end

endmodule

// ----- dv/tb_sorted_fault_code_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_fault_code_table - stimulus and verdict for the fault code table
// A directed pass over the corner cases, then random operation mixes that
// fill the table to capacity, stress the output side and drain it again,
// under three idling profiles; the checker module does all the comparing.
// ----------------------------------------------------------------------------
module tb_sorted_fault_code_table;
  import sfct_pkg::*;

  // opcodes the block does not define; they must still answer once
  localparam logic [OP_W-1:0]   OP_SPARE_6    = 3'd6;
  localparam logic [OP_W-1:0]   OP_SPARE_7    = 3'd7;
  localparam logic [CODE_W-1:0] CODE_ALL_ONES = '1;
  localparam int PRESSURE_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 100;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;
  logic                  m_tlast;
  logic                  hold_start = 1'b0;

  int mismatches;
  int outstanding;
  int results_seen;
  int full_refusals;

  int send_idle_pct = 22;
  int recv_idle_pct = 72;
  int hold_left     = 0;
  int ops_sent [8];

  // codes offered in adds so far; reused to hit duplicates, removes and lookups
  logic [CODE_W-1:0] known_codes [$];

  sorted_fault_code_table dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  sfct_result_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .m_tlast       (m_tlast),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .results_seen  (results_seen),
    .full_refusals (full_refusals)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #15_000_000;
    $display("status: fail");
    $finish;
  end

  // Receiver: random back-pressure, or a long hold-off counted here once
  // the top pulses hold_start.
  always @(posedge clk) begin
    if (hold_start) hold_left = PRESSURE_CYCLES;
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offer one item and hold it until the block takes it. Valid stays high
  // into the next item unless the sender decides to idle first.
  task automatic send_op(input logic [OP_W-1:0] op, input logic [CODE_W-1:0] code,
                         input logic [STAT_W-1:0] st, input logic [POS_W-1:0] pos);
    item_t it;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    it.opcode       = op;
    it.fault_code   = code;
    it.fault_status = st;
    it.position     = pos;
    s_tvalid <= 1'b1;
    s_tdata  <= it;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    ops_sent[op]++;
    if (op == OP_ADD) known_codes.insert(known_codes.size(), code);
  endtask

  // Draw an opcode from the given weights; what is left goes to the spares.
  function automatic logic [OP_W-1:0] pick_op(input int add_w, input int rem_w,
                                              input int look_w, input int read_w,
                                              input int list_w);
    int roll;
    roll = $urandom_range(99);
    if (roll < add_w) return OP_ADD;
    roll -= add_w;
    if (roll < rem_w) return OP_REMOVE;
    roll -= rem_w;
    if (roll < look_w) return OP_LOOKUP;
    roll -= look_w;
    if (roll < read_w) return OP_READ;
    roll -= read_w;
    if (roll < list_w) return ($urandom_range(1) != 0) ? OP_LIST_CONF : OP_LIST_PEND;
    return ($urandom_range(1) != 0) ? OP_SPARE_6 : OP_SPARE_7;
  endfunction

  function automatic logic [CODE_W-1:0] pick_code(input int reuse_pct);
    logic [31:0] raw;
    int          roll;
    raw  = $urandom();
    roll = $urandom_range(99);
    if (known_codes.size() > 0 && roll < reuse_pct)
      return known_codes[$urandom_range(known_codes.size() - 1)];
    if (roll >= 96) return CODE_ALL_ONES;
    if (roll >= 92) return '0;
    return raw[CODE_W-1:0];
  endfunction

  // Bias status bytes towards the confirmed and pending patterns so lists
  // come back long.
  function automatic logic [STAT_W-1:0] pick_status();
    logic [31:0] raw;
    int          roll;
    raw  = $urandom();
    roll = $urandom_range(99);
    if (roll < 35) return raw[STAT_W-1:0] | 8'h09;
    if (roll < 70) return (raw[STAT_W-1:0] | 8'h04) & 8'hF7;
    return raw[STAT_W-1:0];
  endfunction

  task automatic send_random(input int add_w, input int rem_w, input int look_w,
                             input int read_w, input int list_w);
    logic [OP_W-1:0]  op;
    logic [31:0]      raw;
    logic [POS_W-1:0] pos;
    op  = pick_op(add_w, rem_w, look_w, read_w, list_w);
    raw = $urandom();
    pos = ($urandom_range(1) != 0) ? raw[POS_W-1:0] : POS_W'($urandom_range(7));
    send_op(op, pick_code((op == OP_ADD) ? 15 : 65), pick_status(), pos);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table, extreme codes, ordering, duplicates, misses,
    // reads past the fill level, both lists and the spare opcodes.
    send_op(OP_LIST_CONF, '0, '0, '0);
    send_op(OP_LIST_PEND, '0, '0, '0);
    send_op(OP_LOOKUP,    '0, '0, '0);
    send_op(OP_REMOVE,    CODE_ALL_ONES, '0, '0);
    send_op(OP_READ,      '0, '0, '0);
    send_op(OP_ADD,       CODE_ALL_ONES, 8'hFF, '0);
    send_op(OP_ADD,       '0, 8'h09, '0);
    send_op(OP_ADD,       CODE_ALL_ONES, 8'h00, '0);
    send_op(OP_ADD,       24'h800000, 8'h04, '0);
    send_op(OP_ADD,       24'h7FFFFF, 8'hF6, '0);
    send_op(OP_LOOKUP,    CODE_ALL_ONES, '0, '0);
    send_op(OP_LOOKUP,    '0, '0, '0);
    send_op(OP_LOOKUP,    24'h123456, '0, '0);
    send_op(OP_READ,      '0, '0, 5'd0);
    send_op(OP_READ,      '0, '0, 5'd3);
    send_op(OP_READ,      '0, '0, 5'd4);
    send_op(OP_READ,      '0, '0, 5'd31);
    send_op(OP_LIST_CONF, '0, '0, '0);
    send_op(OP_LIST_PEND, '0, '0, '0);
    send_op(OP_REMOVE,    24'h800000, '0, '0);
    send_op(OP_REMOVE,    24'h800000, '0, '0);
    send_op(OP_SPARE_6,   '0, '0, '0);
    send_op(OP_SPARE_7,   CODE_ALL_ONES, 8'hFF, 5'd31);
    send_op(OP_REMOVE,    '0, '0, '0);

    // Fill to capacity and beyond, sender lightly idle, receiver mostly stalled.
    send_idle_pct = 22;
    recv_idle_pct = 72;
    repeat (60) send_random(80, 3, 6, 6, 4);

    // Hold the output off while lists keep coming, so the block backs up
    // and drops s_tready with an item still offered.
    s_tvalid   <= 1'b0;
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    send_random(0, 0, 0, 10, 90);
    repeat (7) send_random(0, 0, 0, 20, 80);

    // Balanced mix with the idling swapped round.
    send_idle_pct = 72;
    recv_idle_pct = 22;
    repeat (35) send_random(25, 25, 15, 15, 15);

    // Back to back on both sides; remove-heavy to walk the table down.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (35) send_random(20, 40, 12, 12, 12);
    s_tvalid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    // give an add or remove walk time to surface a stray result
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d add, %0d remove, %0d lookup, %0d read, %0d list, %0d spare items",
             ops_sent[OP_ADD], ops_sent[OP_REMOVE], ops_sent[OP_LOOKUP], ops_sent[OP_READ],
             ops_sent[OP_LIST_CONF] + ops_sent[OP_LIST_PEND],
             ops_sent[OP_SPARE_6] + ops_sent[OP_SPARE_7]);
    $display("summary: %0d results compared, %0d adds refused on a full table, %0d mismatches",
             results_seen, full_refusals, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
